[hdl/sphere_insertion_overlap_check_assert.svh]
// Assertion macros for the sphere insertion block.
`ifndef SPHERE_INSERTION_OVERLAP_CHECK_ASSERT_SVH
`define SPHERE_INSERTION_OVERLAP_CHECK_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SIOC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sioc assertion failed");

// Next-cycle implication, checked outside reset.
`define SIOC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sioc assertion failed");

`endif

[hdl/sioc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sioc_pkg
// Shared types, codes and helpers of the sphere insertion block.
// ----------------------------------------------------------------------------
package sioc_pkg;

  localparam int MAX_TEMPLATE_DEF = 8;
  localparam int LIST_DEPTH_DEF   = 1024;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_TRY   = 2'd2;

  localparam logic [2:0] ST_PLACED  = 3'd0;
  localparam logic [2:0] ST_OVERLAP = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_LOADED  = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  localparam logic [1:0] CFG_COUNT   = 2'd0;
  localparam logic [1:0] CFG_BOUND_X = 2'd1;
  localparam logic [1:0] CFG_BOUND_Y = 2'd2;
  localparam logic [1:0] CFG_BOUND_Z = 2'd3;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic        [30:0] r;
  } sphere_t;

  typedef struct packed {
    logic    valid;
    sphere_t s;
  } scan_t;

  typedef struct packed {
    logic load;
    logic clear;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_REL, S_ROT, S_SCAN, S_DRAIN, S_EMIT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[hdl/sioc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sioc_cell
// One candidate sphere. Listed spheres pass through the cell one hop per
// cycle; a three-stage pipeline tests each against the held candidate.
// ----------------------------------------------------------------------------
module sioc_cell (
  input  logic                clk,
  input  logic                rst,
  input  sioc_pkg::cell_ctl_t ctl,
  input  sioc_pkg::sphere_t   cand_in,
  input  sioc_pkg::scan_t     scan_in,
  output sioc_pkg::scan_t     scan_out,
  output sioc_pkg::sphere_t   cand,
  output logic                hit
);

  sioc_pkg::scan_t    ent;
  logic signed [32:0] dx, dy, dz;
  logic signed [32:0] ndx, ndy, ndz;
  logic        [31:0] ax, ay, az, rs;
  logic        [31:0] ax_q, ay_q, az_q, rs_q;
  logic        [63:0] sqx, sqy, sqz, rsq;
  logic        [65:0] dsq;
  logic               v1, v2;

  always_comb begin
    dx  = 33'(cand.x) - 33'(ent.s.x);
    dy  = 33'(cand.y) - 33'(ent.s.y);
    dz  = 33'(cand.z) - 33'(ent.s.z);
    ndx = -dx;
    ndy = -dy;
    ndz = -dz;
    // Centres are 32-bit, so each magnitude fits in 32 bits.
    ax  = dx[32] ? ndx[31:0] : dx[31:0];
    ay  = dy[32] ? ndy[31:0] : dy[31:0];
    az  = dz[32] ? ndz[31:0] : dz[31:0];
    rs  = {1'b0, cand.r} + {1'b0, ent.s.r};
    dsq = {2'b00, sqx} + {2'b00, sqy} + {2'b00, sqz};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= '0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      hit <= 1'b0;
    end else begin
      ent <= scan_in;
      v1  <= ent.valid;
      v2  <= v1;
      if (ctl.clear) begin
        hit <= 1'b0;
      end else if (v2 && (dsq <= {2'b00, rsq})) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cand <= cand_in;
    end
    ax_q <= ax;
    ay_q <= ay;
    az_q <= az;
    rs_q <= rs;
    sqx  <= ax_q * ax_q;
    sqy  <= ay_q * ay_q;
    sqz  <= az_q * az_q;
    rsq  <= rs_q * rs_q;
  end

  assign scan_out = ent;

endmodule

[hdl/sioc_rot.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sioc_rot
// Quaternion rotation of one offset. One shared multiplier forms each of the
// nine matrix-offset terms in two halves; each term is rounded to Q16.16.
// ----------------------------------------------------------------------------
module sioc_rot (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] q_w,
  input  logic signed [15:0] q_x,
  input  logic signed [15:0] q_y,
  input  logic signed [15:0] q_z,
  input  logic signed [31:0] rel_x,
  input  logic signed [31:0] rel_y,
  input  logic signed [31:0] rel_z,
  output logic               done,
  output logic signed [39:0] res_x,
  output logic signed [39:0] res_y,
  output logic signed [39:0] res_z
);

  logic signed [31:0] pww, pxx, pyy, pzz, pxy, pwz, pxz, pwy, pyz, pwx;
  logic signed [33:0] m [9];
  logic signed [31:0] relr [3];
  logic signed [39:0] res [3];
  logic        [1:0]  ci, ck;
  logic               ch, run;
  logic        [3:0]  midx;
  logic signed [33:0] mm;
  logic signed [17:0] ml;
  logic signed [16:0] mh;
  logic signed [49:0] pa, lo;
  logic               a_v, a_h, a_lk, b_v, b_lk;
  logic        [1:0]  a_i, b_i;
  logic signed [65:0] tsum;
  logic signed [37:0] term;
  logic signed [39:0] axs, axs_next;

  always_comb begin
    midx     = 4'(ci) * 4'd3 + 4'(ck);
    mm       = m[midx];
    ml       = {1'b0, mm[16:0]};
    mh       = mm[33:17];
    term     = tsum[65:28];
    axs_next = axs + 40'(term);
  end

  // Products are registered from the quaternion, and the matrix from the products.
  always_ff @(posedge clk) begin
    pww  <= q_w * q_w;
    pxx  <= q_x * q_x;
    pyy  <= q_y * q_y;
    pzz  <= q_z * q_z;
    pxy  <= q_x * q_y;
    pwz  <= q_w * q_z;
    pxz  <= q_x * q_z;
    pwy  <= q_w * q_y;
    pyz  <= q_y * q_z;
    pwx  <= q_w * q_x;
    m[0] <= 34'(pww) + 34'(pxx) - 34'(pyy) - 34'(pzz);
    m[1] <= (34'(pxy) - 34'(pwz)) <<< 1;
    m[2] <= (34'(pxz) + 34'(pwy)) <<< 1;
    m[3] <= (34'(pxy) + 34'(pwz)) <<< 1;
    m[4] <= 34'(pww) - 34'(pxx) + 34'(pyy) - 34'(pzz);
    m[5] <= (34'(pyz) - 34'(pwx)) <<< 1;
    m[6] <= (34'(pxz) - 34'(pwy)) <<< 1;
    m[7] <= (34'(pyz) + 34'(pwx)) <<< 1;
    m[8] <= 34'(pww) - 34'(pxx) - 34'(pyy) + 34'(pzz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      ci   <= '0;
      ck   <= '0;
      ch   <= 1'b0;
      a_v  <= 1'b0;
      b_v  <= 1'b0;
      done <= 1'b0;
      axs  <= '0;
    end else begin
      done <= b_v && b_lk && (b_i == 2'd2);
      a_v  <= run;
      b_v  <= a_v && a_h;
      if (start) begin
        run <= 1'b1;
        ci  <= '0;
        ck  <= '0;
        ch  <= 1'b0;
        axs <= '0;
      end else begin
        if (run) begin
          ch <= ~ch;
          if (ch) begin
            if (ck == 2'd2) begin
              ck <= '0;
              ci <= ci + 2'd1;
              if (ci == 2'd2) begin
                run <= 1'b0;
              end
            end else begin
              ck <= ck + 2'd1;
            end
          end
        end
        if (b_v) begin
          axs <= b_lk ? '0 : axs_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      relr[0] <= rel_x;
      relr[1] <= rel_y;
      relr[2] <= rel_z;
    end
    // Low half first, then the high half weighted by 2^17.
    pa   <= ch ? 50'(mh * relr[ck]) : ml * relr[ck];
    a_h  <= ch;
    a_i  <= ci;
    a_lk <= (ck == 2'd2);
    if (a_v && !a_h) begin
      lo <= pa;
    end
    tsum <= (66'(pa) <<< 17) + 66'(lo) + 66'sd134217728;
    b_i  <= a_i;
    b_lk <= a_lk;
    if (b_v && b_lk) begin
      res[b_i] <= axs_next;
    end
  end

  assign res_x = res[0];
  assign res_y = res[1];
  assign res_z = res[2];

endmodule

[hdl/sphere_insertion_overlap_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_insertion_overlap_check
// Clump insertion with overlap rejection against a list of placed spheres.
// ----------------------------------------------------------------------------
// Channel   Handshake        Payload
// input     start / busy     opcode, sphere_index, pos_*, sphere_radius, quat_*
// result    strobe           status, placed_*, placed_radius, inserted_count, last
// config    wr_en            wr_index, wr_data
//
// Clear and load give their single result the cycle after acceptance.
// A try rotates each of its N template spheres in turn on the rotator's
// shared multiplier (a lone sphere is not rotated), then streams the list
// through a row of MAX_TEMPLATE cells, one entry a cycle from the list
// memory read port, and reports a placement as a burst of N results.
// Reset empties the list at once; results cannot be stalled.
// ----------------------------------------------------------------------------
module sphere_insertion_overlap_check #(
  parameter int MAX_TEMPLATE = sioc_pkg::MAX_TEMPLATE_DEF,
  parameter int LIST_DEPTH   = sioc_pkg::LIST_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic [2:0]         sphere_index,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [30:0]        sphere_radius,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [31:0]        wr_data,
  output logic               strobe,
  output logic [2:0]         status,
  output logic signed [31:0] placed_x,
  output logic signed [31:0] placed_y,
  output logic signed [31:0] placed_z,
  output logic [30:0]        placed_radius,
  output logic [3:0]         inserted_count,
  output logic               last
);

  `include "sphere_insertion_overlap_check_assert.svh"

  localparam int TW        = (MAX_TEMPLATE > 1) ? $clog2(MAX_TEMPLATE) : 1;
  localparam int NW        = $clog2(MAX_TEMPLATE + 1);
  localparam int AW        = $clog2(LIST_DEPTH);
  localparam int CW        = AW + 1;
  localparam int DRAIN_LEN = MAX_TEMPLATE + 6;
  localparam int DW        = $clog2(DRAIN_LEN);

  sioc_pkg::state_t state, state_next;

  logic [3:0]         sphere_count;
  logic signed [31:0] bound_x, bound_y, bound_z;
  logic signed [31:0] tx [MAX_TEMPLATE];
  logic signed [31:0] ty [MAX_TEMPLATE];
  logic signed [31:0] tz [MAX_TEMPLATE];
  logic [30:0]        tr [MAX_TEMPLATE];
  sioc_pkg::sphere_t  mem [LIST_DEPTH];
  sioc_pkg::sphere_t  mem_q;
  logic               rd_valid;

  logic signed [31:0] px, py, pz;
  logic signed [15:0] qw, qx, qy, qz;
  logic [NW-1:0]      n_r, n_clamp, j;
  logic [CW-1:0]      list_count, rd_addr;
  logic [DW-1:0]      drain;
  logic [TW-1:0]      jt;

  logic               accept, full, rd_go, load_en, rot_start, rot_done;
  logic               emit, emit_last, j_inc, hit_any, last_j;
  logic [2:0]         emit_status;
  sioc_pkg::sphere_t  emit_sph, cand_new;
  logic signed [31:0] rel_x, rel_y, rel_z;
  logic signed [39:0] res_x, res_y, res_z;

  sioc_pkg::scan_t     scan [MAX_TEMPLATE];
  sioc_pkg::sphere_t   cand_all [MAX_TEMPLATE];
  sioc_pkg::cell_ctl_t ctl [MAX_TEMPLATE];
  logic [MAX_TEMPLATE-1:0] hits, active;

  assign busy   = (state != sioc_pkg::S_IDLE);
  assign accept = start && !busy;
  assign jt     = j[TW-1:0];
  assign last_j = (j == n_r - NW'(1));

  always_comb begin
    if (sphere_count == 4'd0) begin
      n_clamp = NW'(1);
    end else if (32'(sphere_count) > MAX_TEMPLATE) begin
      n_clamp = NW'(MAX_TEMPLATE);
    end else begin
      n_clamp = NW'(sphere_count);
    end
    full  = (32'(list_count) + 32'(n_clamp)) > LIST_DEPTH;
    rd_go = (state == sioc_pkg::S_SCAN) && (rd_addr < list_count);
    rel_x = sioc_pkg::sat32(40'(tx[jt]) - 40'(bound_x));
    rel_y = sioc_pkg::sat32(40'(ty[jt]) - 40'(bound_y));
    rel_z = sioc_pkg::sat32(40'(tz[jt]) - 40'(bound_z));
  end

  // Row of cells: the list stream enters at cell 0.
  assign scan[0] = '{valid: rd_valid, s: mem_q};

  for (genvar g = 0; g < MAX_TEMPLATE; g++) begin : g_cell
    assign ctl[g]    = '{load: load_en && (jt == TW'(g)), clear: accept};
    assign active[g] = (32'(n_r) > g);
    if (g < MAX_TEMPLATE - 1) begin : g_mid
      sioc_cell u_cell (
        .clk(clk), .rst(rst), .ctl(ctl[g]), .cand_in(cand_new),
        .scan_in(scan[g]), .scan_out(scan[g+1]), .cand(cand_all[g]),
        .hit(hits[g])
      );
    end else begin : g_end
      sioc_cell u_cell (
        .clk(clk), .rst(rst), .ctl(ctl[g]), .cand_in(cand_new),
        .scan_in(scan[g]), .scan_out(), .cand(cand_all[g]),
        .hit(hits[g])
      );
    end
  end

  assign hit_any = |(hits & active);

  sioc_rot u_rot (
    .clk(clk), .rst(rst), .start(rot_start),
    .q_w(qw), .q_x(qx), .q_y(qy), .q_z(qz),
    .rel_x(rel_x), .rel_y(rel_y), .rel_z(rel_z),
    .done(rot_done), .res_x(res_x), .res_y(res_y), .res_z(res_z)
  );

  always_comb begin
    state_next  = state;
    emit        = 1'b0;
    emit_status = sioc_pkg::ST_PLACED;
    emit_sph    = '0;
    emit_last   = 1'b1;
    load_en     = 1'b0;
    rot_start   = 1'b0;
    j_inc       = 1'b0;
    cand_new    = '{x: sioc_pkg::sat32(res_x + 40'(px)),
                    y: sioc_pkg::sat32(res_y + 40'(py)),
                    z: sioc_pkg::sat32(res_z + 40'(pz)), r: tr[jt]};
    case (state)
      sioc_pkg::S_IDLE: begin
        if (accept) begin
          case (opcode)
            sioc_pkg::OP_CLEAR: begin
              emit        = 1'b1;
              emit_status = sioc_pkg::ST_CLEARED;
            end
            sioc_pkg::OP_LOAD: begin
              emit        = 1'b1;
              emit_status = sioc_pkg::ST_LOADED;
            end
            sioc_pkg::OP_TRY: begin
              if (full) begin
                emit        = 1'b1;
                emit_status = sioc_pkg::ST_FULL;
              end else begin
                state_next = sioc_pkg::S_PREP;
              end
            end
            default: begin
              state_next = sioc_pkg::S_IDLE;
            end
          endcase
        end
      end
      sioc_pkg::S_PREP: begin
        state_next = sioc_pkg::S_REL;
      end
      sioc_pkg::S_REL: begin
        if (n_r == NW'(1)) begin
          // A lone sphere sits on the point itself, unrotated.
          load_en    = 1'b1;
          cand_new   = '{x: px, y: py, z: pz, r: tr[0]};
          state_next = sioc_pkg::S_SCAN;
        end else begin
          rot_start  = 1'b1;
          state_next = sioc_pkg::S_ROT;
        end
      end
      sioc_pkg::S_ROT: begin
        if (rot_done) begin
          load_en    = 1'b1;
          j_inc      = 1'b1;
          state_next = last_j ? sioc_pkg::S_SCAN : sioc_pkg::S_REL;
        end
      end
      sioc_pkg::S_SCAN: begin
        if (!rd_go) begin
          state_next = sioc_pkg::S_DRAIN;
        end
      end
      sioc_pkg::S_DRAIN: begin
        if (drain == DW'(DRAIN_LEN - 1)) begin
          if (hit_any) begin
            emit        = 1'b1;
            emit_status = sioc_pkg::ST_OVERLAP;
            state_next  = sioc_pkg::S_IDLE;
          end else begin
            state_next = sioc_pkg::S_EMIT;
          end
        end
      end
      sioc_pkg::S_EMIT: begin
        emit        = 1'b1;
        emit_status = sioc_pkg::ST_PLACED;
        emit_sph    = cand_all[jt];
        emit_last   = last_j;
        j_inc       = 1'b1;
        if (last_j) begin
          state_next = sioc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sioc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sioc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_count <= 4'd1;
      bound_x      <= '0;
      bound_y      <= '0;
      bound_z      <= '0;
      list_count   <= '0;
      strobe       <= 1'b0;
      rd_valid     <= 1'b0;
      rd_addr      <= '0;
      drain        <= '0;
      j            <= '0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          sioc_pkg::CFG_COUNT:   sphere_count <= wr_data[3:0];
          sioc_pkg::CFG_BOUND_X: bound_x      <= wr_data;
          sioc_pkg::CFG_BOUND_Y: bound_y      <= wr_data;
          sioc_pkg::CFG_BOUND_Z: bound_z      <= wr_data;
          default:               sphere_count <= sphere_count;
        endcase
      end
      strobe   <= emit;
      rd_valid <= rd_go;
      if (accept) begin
        j       <= '0;
        rd_addr <= '0;
        drain   <= '0;
        if (opcode == sioc_pkg::OP_CLEAR) begin
          list_count <= '0;
        end
      end else begin
        // The sphere index wraps to zero after the last sphere, so reporting
        // starts again from the first candidate.
        if (j_inc) begin
          j <= last_j ? '0 : j + NW'(1);
        end
        if (rd_go) begin
          rd_addr <= rd_addr + CW'(1);
        end
        if (state == sioc_pkg::S_DRAIN) begin
          drain <= drain + DW'(1);
        end
        if (state == sioc_pkg::S_EMIT) begin
          list_count <= list_count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px  <= pos_x;
      py  <= pos_y;
      pz  <= pos_z;
      qw  <= quat_w;
      qx  <= quat_x;
      qy  <= quat_y;
      qz  <= quat_z;
      n_r <= n_clamp;
      if ((opcode == sioc_pkg::OP_LOAD) && (32'(sphere_index) < MAX_TEMPLATE)) begin
        tx[TW'(sphere_index)] <= pos_x;
        ty[TW'(sphere_index)] <= pos_y;
        tz[TW'(sphere_index)] <= pos_z;
        tr[TW'(sphere_index)] <= sphere_radius;
      end
    end
    if (emit) begin
      status         <= emit_status;
      placed_x       <= emit_sph.x;
      placed_y       <= emit_sph.y;
      placed_z       <= emit_sph.z;
      placed_radius  <= emit_sph.r;
      inserted_count <= (emit_status == sioc_pkg::ST_PLACED) ? 4'(n_r) : 4'd0;
      last           <= emit_last;
    end
  end

  // List memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (state == sioc_pkg::S_EMIT) begin
      mem[list_count[AW-1:0]] <= cand_all[jt];
    end
    mem_q <= mem[rd_addr[AW-1:0]];
  end

  `SIOC_ASSERT_NEXT(a_burst_contiguous, strobe && !last, strobe)
  `SIOC_ASSERT_IMPL(a_single_not_placed, strobe && (status != sioc_pkg::ST_PLACED), last)
  `SIOC_ASSERT_IMPL(a_count_bound, 1'b1, 32'(list_count) <= LIST_DEPTH)
  `SIOC_ASSERT_IMPL(a_no_emit_while_scan, state == sioc_pkg::S_SCAN, !emit)

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere insertion testbench
// Drives clear, load and try items plus register writes into the block and
// checks every result against an in-bench model of clump placement.
// ----------------------------------------------------------------------------

class placement_board;
  logic [2:0]         exp_status[$];
  logic signed [31:0] exp_x[$];
  logic signed [31:0] exp_y[$];
  logic signed [31:0] exp_z[$];
  logic [30:0]        exp_r[$];
  logic [3:0]         exp_cnt[$];
  logic               exp_last[$];
  int                 mismatches;

  logic signed [31:0] tpl_x[8];
  logic signed [31:0] tpl_y[8];
  logic signed [31:0] tpl_z[8];
  logic [30:0]        tpl_r[8];
  logic signed [31:0] lst_x[$];
  logic signed [31:0] lst_y[$];
  logic signed [31:0] lst_z[$];
  logic [30:0]        lst_r[$];
  logic [3:0]         count_reg;
  logic signed [31:0] bnd_x, bnd_y, bnd_z;

  function new();
    mismatches = 0;
    count_reg = 1;
    bnd_x = 0;
    bnd_y = 0;
    bnd_z = 0;
    for (int i = 0; i < 8; i++) begin
      tpl_x[i] = 0; tpl_y[i] = 0; tpl_z[i] = 0; tpl_r[i] = 0;
    end
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      sioc_pkg::CFG_COUNT:   count_reg = val[3:0];
      sioc_pkg::CFG_BOUND_X: bnd_x = val;
      sioc_pkg::CFG_BOUND_Y: bnd_y = val;
      default:               bnd_z = val;
    endcase
  endfunction

  function int pending();
    return exp_status.size();
  endfunction

  function int list_len();
    return lst_x.size();
  endfunction

  function void push(logic [2:0] st, logic signed [31:0] x, logic signed [31:0] y,
                     logic signed [31:0] z, logic [30:0] r, logic [3:0] c, logic l);
    exp_status.push_back(st); exp_x.push_back(x); exp_y.push_back(y);
    exp_z.push_back(z); exp_r.push_back(r); exp_cnt.push_back(c); exp_last.push_back(l);
  endfunction

  function longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Rounded product of a Q2.28 matrix entry and a Q16.16 offset.
  function longint round_term(longint m, longint r);
    return (m * r + (64'sd1 <<< 27)) >>> 28;
  endfunction

  function bit touches(logic signed [31:0] cx, logic signed [31:0] cy,
                       logic signed [31:0] cz, logic [30:0] r);
    logic [127:0] sum, rs;
    longint d[3];
    for (int i = 0; i < lst_x.size(); i++) begin
      d[0] = longint'(cx) - longint'(lst_x[i]);
      d[1] = longint'(cy) - longint'(lst_y[i]);
      d[2] = longint'(cz) - longint'(lst_z[i]);
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        if (d[k] < 0) d[k] = -d[k];
        sum += 128'(d[k]) * 128'(d[k]);
      end
      rs = 128'(r) + 128'(lst_r[i]);
      if (sum <= rs * rs) return 1;
    end
    return 0;
  endfunction

  function void note_item(logic [1:0] op, logic [2:0] idx, logic signed [31:0] px,
                          logic signed [31:0] py, logic signed [31:0] pz,
                          logic [30:0] rad, logic signed [15:0] qw,
                          logic signed [15:0] qx, logic signed [15:0] qy,
                          logic signed [15:0] qz);
    int n;
    longint w, x, y, z;
    longint m[3][3];
    longint rel[3], rot[3];
    logic signed [31:0] cx[8], cy[8], cz[8];
    if (op == sioc_pkg::OP_CLEAR) begin
      lst_x.delete(); lst_y.delete(); lst_z.delete(); lst_r.delete();
      push(sioc_pkg::ST_CLEARED, 0, 0, 0, 0, 0, 1);
      return;
    end
    if (op == sioc_pkg::OP_LOAD) begin
      tpl_x[idx] = px; tpl_y[idx] = py; tpl_z[idx] = pz; tpl_r[idx] = rad;
      push(sioc_pkg::ST_LOADED, 0, 0, 0, 0, 0, 1);
      return;
    end
    if (op != sioc_pkg::OP_TRY) return;
    n = count_reg;
    if (n < 1) n = 1;
    if (n > 8) n = 8;
    if (lst_x.size() + n > 1024) begin
      push(sioc_pkg::ST_FULL, 0, 0, 0, 0, 0, 1);
      return;
    end
    w = qw; x = qx; y = qy; z = qz;
    m[0][0] = w*w + x*x - y*y - z*z;
    m[0][1] = 2 * (x*y - w*z);
    m[0][2] = 2 * (x*z + w*y);
    m[1][0] = 2 * (x*y + w*z);
    m[1][1] = w*w - x*x + y*y - z*z;
    m[1][2] = 2 * (y*z - w*x);
    m[2][0] = 2 * (x*z - w*y);
    m[2][1] = 2 * (y*z + w*x);
    m[2][2] = w*w - x*x - y*y + z*z;
    if (n == 1) begin
      cx[0] = px; cy[0] = py; cz[0] = pz;
    end else begin
      for (int j = 0; j < n; j++) begin
        rel[0] = clip32(longint'(tpl_x[j]) - longint'(bnd_x));
        rel[1] = clip32(longint'(tpl_y[j]) - longint'(bnd_y));
        rel[2] = clip32(longint'(tpl_z[j]) - longint'(bnd_z));
        for (int i = 0; i < 3; i++)
          rot[i] = round_term(m[i][0], rel[0]) + round_term(m[i][1], rel[1]) +
                   round_term(m[i][2], rel[2]);
        cx[j] = 32'(clip32(rot[0] + longint'(px)));
        cy[j] = 32'(clip32(rot[1] + longint'(py)));
        cz[j] = 32'(clip32(rot[2] + longint'(pz)));
      end
    end
    for (int j = 0; j < n; j++) begin
      if (touches(cx[j], cy[j], cz[j], tpl_r[j])) begin
        push(sioc_pkg::ST_OVERLAP, 0, 0, 0, 0, 0, 1);
        return;
      end
    end
    for (int j = 0; j < n; j++) begin
      lst_x.push_back(cx[j]); lst_y.push_back(cy[j]);
      lst_z.push_back(cz[j]); lst_r.push_back(tpl_r[j]);
      push(sioc_pkg::ST_PLACED, cx[j], cy[j], cz[j], tpl_r[j], 4'(n), j + 1 == n);
    end
  endfunction

  function void check_result(logic [2:0] st, logic signed [31:0] x,
                             logic signed [31:0] y, logic signed [31:0] z,
                             logic [30:0] r, logic [3:0] c, logic l);
    if (exp_status.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: status %0d", st);
      return;
    end
    if (st !== exp_status[0] || x !== exp_x[0] || y !== exp_y[0] || z !== exp_z[0] ||
        r !== exp_r[0] || c !== exp_cnt[0] || l !== exp_last[0]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp st=%0d %0d %0d %0d r=%0d n=%0d l=%0d, got st=%0d %0d %0d %0d r=%0d n=%0d l=%0d",
                 exp_status[0], exp_x[0], exp_y[0], exp_z[0], exp_r[0], exp_cnt[0],
                 exp_last[0], st, x, y, z, r, c, l);
    end
    void'(exp_status.pop_front()); void'(exp_x.pop_front()); void'(exp_y.pop_front());
    void'(exp_z.pop_front()); void'(exp_r.pop_front()); void'(exp_cnt.pop_front());
    void'(exp_last.pop_front());
  endfunction
endclass

module testbench;
  logic clk, rst, start, busy, wr_en, strobe, last;
  logic [1:0] opcode, wr_index;
  logic [2:0] sphere_index, status;
  logic signed [31:0] pos_x, pos_y, pos_z, placed_x, placed_y, placed_z;
  logic [30:0] sphere_radius, placed_radius;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  logic [31:0] wr_data;
  logic [3:0] inserted_count;
  longint cycles;
  bit calm;
  int n_tpl;
  placement_board board;

  sphere_insertion_overlap_check DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && strobe)
      board.check_result(status, placed_x, placed_y, placed_z, placed_radius,
                         inserted_count, last);

  // The start line drops only when the sender idles, so items may follow
  // one another with no gap.
  task automatic pause_random();
    int g;
    if (!calm && $urandom_range(0, 3) == 0) begin
      g = $urandom_range(1, 11);
      start <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send(logic [1:0] op, logic [2:0] idx, logic [31:0] px, logic [31:0] py,
                      logic [31:0] pz, logic [30:0] rad, logic [15:0] qw,
                      logic [15:0] qx, logic [15:0] qy, logic [15:0] qz);
    pause_random();
    start <= 1; opcode <= op; sphere_index <= idx;
    pos_x <= px; pos_y <= py; pos_z <= pz; sphere_radius <= rad;
    quat_w <= qw; quat_x <= qx; quat_y <= qy; quat_z <= qz;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(op, idx, px, py, pz, rad, qw, qx, qy, qz);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (board.pending() != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [31:0] val);
    drain();
    wr_en <= 1; wr_index <= idx; wr_data <= val;
    @(posedge clk);
    wr_en <= 0;
    board.write_reg(idx, val);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $urandom_range(0, 32'h00400000) - 32'h00200000;
    endcase
  endfunction

  task automatic load_tpl(int k, bit wide);
    for (int i = 0; i < k; i++)
      send(sioc_pkg::OP_LOAD, i, wide ? rnd_coord() : ($urandom_range(0, 32'h80000) - 32'h40000),
           wide ? rnd_coord() : ($urandom_range(0, 32'h80000) - 32'h40000),
           wide ? rnd_coord() : ($urandom_range(0, 32'h80000) - 32'h40000),
           wide && $urandom_range(0, 1) ? 31'($urandom) : $urandom_range(0, 32'h20000),
           0, 0, 0, 0);
  endtask

  task automatic try_rand();
    logic [15:0] q[4];
    for (int i = 0; i < 4; i++) q[i] = $urandom_range(0, 2) == 0 ? 16'($urandom)
                                       : 16'($urandom_range(0, 16'h8000) - 16'h4000);
    send(sioc_pkg::OP_TRY, $urandom, rnd_coord(), rnd_coord(), rnd_coord(), $urandom,
         q[0], q[1], q[2], q[3]);
  endtask

  initial begin
    board = new();
    cycles = 0; calm = 0;
    rst = 1; start = 0; wr_en = 0; wr_index = 0; wr_data = 0;
    opcode = 0; sphere_index = 0; pos_x = 0; pos_y = 0; pos_z = 0; sphere_radius = 0;
    quat_w = 0; quat_x = 0; quat_y = 0; quat_z = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed part: template extremes, every opcode, touching spheres.
    send(sioc_pkg::OP_LOAD, 0, 0, 0, 0, 31'h7FFFFFFF, 0, 0, 0, 0);
    send(sioc_pkg::OP_TRY, 0, 32'h7FFFFFFF, 32'h80000000, 0, 0, 16'h4000, 0, 0, 0);
    send(sioc_pkg::OP_TRY, 0, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0, 0);
    send(sioc_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(sioc_pkg::OP_LOAD, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 0);
    send(sioc_pkg::OP_TRY, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(sioc_pkg::OP_TRY, 0, 32'h20000, 0, 0, 0, 0, 0, 0, 0);
    send(sioc_pkg::OP_TRY, 0, 32'h20001, 0, 0, 0, 0, 0, 0, 0);
    send(2'd3, 3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF,
         16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(sioc_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    load_tpl(8, 1);
    set_reg(sioc_pkg::CFG_COUNT, 8);
    set_reg(sioc_pkg::CFG_BOUND_X, 32'h80000000);
    set_reg(sioc_pkg::CFG_BOUND_Y, 32'h7FFFFFFF);
    set_reg(sioc_pkg::CFG_BOUND_Z, 32'hFFFFFFFF);
    send(sioc_pkg::OP_TRY, 0, 0, 0, 0, 0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send(sioc_pkg::OP_TRY, 0, 0, 0, 0, 0, 16'h4000, 0, 0, 0);
    set_reg(sioc_pkg::CFG_COUNT, 0);
    send(sioc_pkg::OP_TRY, 0, 32'h123456, 0, 0, 0, 0, 0, 0, 0);
    set_reg(sioc_pkg::CFG_COUNT, 15);
    send(sioc_pkg::OP_TRY, 0, 32'h300000, 0, 0, 0, 16'h2D41, 0, 16'h2D41, 0);
    drain();
    // Random phases with different template sizes and bounds.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) calm = 1;
      n_tpl = $urandom_range(1, 8);
      set_reg(sioc_pkg::CFG_COUNT, ph == 0 ? 1 : n_tpl);
      set_reg(sioc_pkg::CFG_BOUND_X, $urandom_range(0, 3) == 0 ? $urandom
                                     : $urandom_range(0, 32'h40000) - 32'h20000);
      set_reg(sioc_pkg::CFG_BOUND_Y, $urandom_range(0, 32'h40000) - 32'h20000);
      set_reg(sioc_pkg::CFG_BOUND_Z, $urandom_range(0, 32'h40000) - 32'h20000);
      send(sioc_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      load_tpl(8, ph == 3);
      for (int i = 0; i < 10; i++) begin
        if ($urandom_range(0, 19) == 0)
          send(sioc_pkg::OP_LOAD, $urandom, $urandom, $urandom, $urandom,
               $urandom_range(0, 32'h20000), 0, 0, 0, 0);
        else
          try_rand();
      end
    end
    // Fill the list until it reports full, starting from an empty list.
    set_reg(sioc_pkg::CFG_COUNT, 8);
    send(sioc_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    while (board.list_len() + 8 <= 1024) begin
      calm = 1;
      send(sioc_pkg::OP_TRY, 0, 32'h1000000 * (board.list_len() / 8) + 32'h10000000,
           32'h40000000, 0, 0, 16'h4000, 0, 0, 0);
    end
    send(sioc_pkg::OP_TRY, 0, 0, 0, 0, 0, 16'h4000, 0, 0, 0);
    drain();
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
